### design/smss_pkg.sv
// Shared types and constants for the sorted-matrix staircase search core.
`default_nettype none

package smss_pkg;

	// Request codes carried on req_type.
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SEARCH = 1'b1;

	// Configuration register indexes, taken from paddr[2].
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	// Configuration register width and reset values.
	localparam int unsigned COUNT_W = 5;
	localparam logic [COUNT_W-1:0] ROW_COUNT_RST = 5'd16;
	localparam logic [COUNT_W-1:0] COL_COUNT_RST = 5'd16;

	// Search sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_MISS
	} state_t;

endpackage

`default_nettype wire

### design/smss_ram.sv
// Single-port-write, single-port-read matrix memory with a registered read.
`default_nettype none

module smss_ram #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32,
	parameter int unsigned AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### design/sorted_matrix_staircase_search_core.sv
// A load writes the matrix in the cycle of its transfer and gives no result.
// A search over a non-empty area issues its first read at the transfer, then one read per
// step of the walk (at most row_count + col_count - 1 reads); the result is registered once
// the last read is compared and the result register is free. Loads are taken one per cycle
// while no search is in progress; a search stalls new requests until its result is loaded.
// Reset sets row_count and col_count to 16; the matrix contents are undefined until loaded.
`default_nettype none

module sorted_matrix_staircase_search_core #(
	parameter int unsigned ROWS_MAX   = 16,
	parameter int unsigned COLS_MAX   = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	// Configuration port.
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,

	// Request channel.
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               req_type,
	input  wire logic [3:0]         row_index,
	input  wire logic [3:0]         col_index,
	input  wire logic signed [31:0] element_value,
	input  wire logic signed [31:0] target_value,

	// Result channel.
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    found,
	output logic      [3:0]         found_row,
	output logic      [3:0]         found_col
);

	localparam int unsigned CELLS = ROWS_MAX * COLS_MAX;
	localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned RW    = $clog2(ROWS_MAX + 1);
	localparam int unsigned CNW   = $clog2(COLS_MAX + 1);
	localparam int unsigned CIW   = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
	localparam int unsigned XW    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam logic [AW-1:0] COLS_A = AW'(COLS_MAX);

	smss_pkg::state_t state_q, state_d;

	logic [smss_pkg::COUNT_W-1:0] row_count_q;
	logic [smss_pkg::COUNT_W-1:0] col_count_q;

	logic [RW-1:0]          r_q, r_d;
	logic [CIW-1:0]         c_q, c_d;
	logic signed [31:0]     target_q;
	logic                   target_ld;

	logic [RW-1:0]          rows_eff;
	logic [CNW-1:0]         cols_eff;

	logic                   accept;
	logic                   out_free;
	logic                   out_ld;
	logic                   res_found;
	logic [3:0]             res_row;
	logic [3:0]             res_col;

	logic                   cfg_wr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [DATA_WIDTH-1:0]  wr_data;
	logic signed [63:0]     elem_ext;
	logic                   rd_en;
	logic [RW-1:0]          rd_row;
	logic [CIW-1:0]         rd_col;
	logic [AW-1:0]          rd_addr;
	logic [DATA_WIDTH-1:0]  rd_data;

	logic signed [XW-1:0]   cell_x;
	logic signed [XW-1:0]   target_x;
	logic                   hit;
	logic                   gt;
	logic                   walk_end;

	// Configuration registers; writes complete in the access phase.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= smss_pkg::ROW_COUNT_RST;
			col_count_q <= smss_pkg::COL_COUNT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == smss_pkg::REG_ROW_COUNT) begin
				row_count_q <= pwdata[smss_pkg::COUNT_W-1:0];
			end else begin
				col_count_q <= pwdata[smss_pkg::COUNT_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == smss_pkg::REG_ROW_COUNT) begin
			prdata = 32'(row_count_q);
		end else begin
			prdata = 32'(col_count_q);
		end
	end

	// Counts above the array size act as the array size.
	assign rows_eff = (32'(row_count_q) > ROWS_MAX) ? RW'(ROWS_MAX) : RW'(row_count_q);
	assign cols_eff = (32'(col_count_q) > COLS_MAX) ? CNW'(COLS_MAX) : CNW'(col_count_q);

	// Handshake on both channels.
	assign in_stall = (state_q != smss_pkg::ST_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign out_free = ~out_valid | ~out_stall;

	// Loads outside the array are dropped; elements wrap to the stored width.
	assign elem_ext = 64'(element_value);
	assign wr_data  = elem_ext[DATA_WIDTH-1:0];
	assign wr_addr  = AW'(row_index) * COLS_A + AW'(col_index);
	assign wr_en    = accept && (req_type == smss_pkg::REQ_LOAD)
	                  && (32'(row_index) < ROWS_MAX) && (32'(col_index) < COLS_MAX);

	smss_ram #(
		.DEPTH(CELLS),
		.WIDTH(DATA_WIDTH),
		.AW   (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_addr = AW'(rd_row) * COLS_A + AW'(rd_col);

	// Compare the current cell with the target at full signed width.
	assign cell_x   = XW'($signed(rd_data));
	assign target_x = XW'(target_q);
	assign hit      = (cell_x == target_x);
	assign gt       = (cell_x > target_x);
	assign walk_end = hit || (gt && (c_q == '0)) || (!gt && ((r_q + RW'(1)) == rows_eff));

	// Sequencer: next state, memory reads and result capture.
	always_comb begin
		state_d   = state_q;
		r_d       = r_q;
		c_d       = c_q;
		rd_en     = 1'b0;
		rd_row    = r_q;
		rd_col    = c_q;
		target_ld = 1'b0;
		out_ld    = 1'b0;
		res_found = 1'b0;
		res_row   = 4'd0;
		res_col   = 4'd0;
		case (state_q)
			smss_pkg::ST_IDLE: begin
				if (accept && (req_type == smss_pkg::REQ_SEARCH)) begin
					target_ld = 1'b1;
					if ((rows_eff == '0) || (cols_eff == '0)) begin
						state_d = smss_pkg::ST_MISS;
					end else begin
						// Start at the top-right corner of the area in use.
						r_d     = '0;
						c_d     = CIW'(cols_eff - CNW'(1));
						rd_en   = 1'b1;
						rd_row  = '0;
						rd_col  = CIW'(cols_eff - CNW'(1));
						state_d = smss_pkg::ST_WALK;
					end
				end
			end
			smss_pkg::ST_WALK: begin
				if (walk_end) begin
					// Hold the read data until the result register is free.
					if (out_free) begin
						out_ld    = 1'b1;
						res_found = hit;
						res_row   = hit ? 4'(r_q) : 4'd0;
						res_col   = hit ? 4'(c_q) : 4'd0;
						state_d   = smss_pkg::ST_IDLE;
					end
				end else if (gt) begin
					c_d    = c_q - CIW'(1);
					rd_en  = 1'b1;
					rd_col = c_q - CIW'(1);
				end else begin
					r_d    = r_q + RW'(1);
					rd_en  = 1'b1;
					rd_row = r_q + RW'(1);
				end
			end
			smss_pkg::ST_MISS: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = smss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Walk position and target.
	always_ff @(posedge clk) begin
		r_q <= r_d;
		c_q <= c_d;
		if (target_ld) begin
			target_q <= target_value;
		end
	end

	// Output register; a result waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ld) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			found     <= res_found;
			found_row <= res_row;
			found_col <= res_col;
		end
	end

endmodule

`default_nettype wire
